### rtl/md5_pkg.sv
// Package for the MD5 engine: constants and round tables.
package md5_pkg;

	localparam int WORD_W    = 32;
	localparam int BUF_WORDS = 16;

	localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
	localparam logic [WORD_W-1:0] INIT_B = 32'hefcdab89;
	localparam logic [WORD_W-1:0] INIT_C = 32'h98badcfe;
	localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [3:0] LEN_LO_WD = 4'd14;
	localparam logic [3:0] LEN_HI_WD = 4'd15;
	localparam logic [5:0] LAST_RND  = 6'd63;

	// round constants, floor(abs(sin(i+1)) * 2^32)
	function automatic logic [WORD_W-1:0] k_const(input logic [5:0] r);
		logic [WORD_W-1:0] k;
		unique case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amt(input logic [5:0] r);
		logic [4:0] s;
		unique case ({r[5:4], r[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// message word index used by each round
	function automatic logic [3:0] msg_idx(input logic [5:0] r);
		logic [3:0] g;
		unique case (r[5:4])
			2'd0: g = r[3:0];
			2'd1: g = 4'(5 * r[3:0] + 1);
			2'd2: g = 4'(3 * r[3:0] + 5);
			2'd3: g = 4'(7 * r[3:0]);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

### rtl/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/md5_hash_engine_unit.sv
// MD5 engine: byte-wide message input, 128-bit digest output.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  input    | in_valid / in_ready  | data_byte[7:0], has_byte, last
//  output   | out_valid / out_ready| digest_low[63:0], digest_high[63:0]
//
// A byte is taken while in_ready is high; every 64th byte starts a load,
// the rounds and a chaining add, with in_ready low. A last transaction
// adds padding, a second compression if the length spills over, two length
// writes and a final compression before the digest.
// The message block sits as 16 words in a RAM; rounds read it one word ahead.
// Reset returns the chaining values and counters to their initial state.
// A digest waiting on out_ready stalls only the next final chaining add.
module md5_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_low,
	output logic [63:0] digest_high
);

	localparam int AW = $clog2(md5_pkg::BUF_WORDS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN_LO, ST_LEN_HI, ST_PRIME, ST_ROUND, ST_ADD
	} state_t;

	state_t st_q;

	logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] word_q;
	logic [5:0]  cnt_q;
	logic [5:0]  round_q;
	logic [63:0] bits_q;
	logic        pad_q, pad80_q, final_q;

	logic        push_en;
	logic [7:0]  push_val;
	logic        ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0] ram_wdata, ram_rdata;
	logic [31:0] f_val, t_val, b_new;
	logic [63:0] rot_w;
	logic [5:0]  round_nx;

	assign in_ready = (st_q == ST_IDLE);

	always_comb begin
		push_en  = 1'b0;
		push_val = data_byte;
		if (st_q == ST_IDLE) begin
			push_en = in_valid && has_byte;
		end else if (st_q == ST_PAD) begin
			push_en  = !(pad80_q && cnt_q == md5_pkg::LEN_POS);
			push_val = pad80_q ? 8'h00 : md5_pkg::PAD_BYTE;
		end
	end

	always_comb begin
		ram_we    = push_en && (cnt_q[1:0] == 2'd3);
		ram_waddr = cnt_q[5:2];
		ram_wdata = {push_val, word_q[23:0]};
		if (st_q == ST_LEN_LO) begin
			ram_we    = 1'b1;
			ram_waddr = md5_pkg::LEN_LO_WD;
			ram_wdata = bits_q[31:0];
		end else if (st_q == ST_LEN_HI) begin
			ram_we    = 1'b1;
			ram_waddr = md5_pkg::LEN_HI_WD;
			ram_wdata = bits_q[63:32];
		end
	end

	// read one round ahead; the load cycle fetches the first word
	assign round_nx  = round_q + 6'd1;
	assign ram_raddr = (st_q == ST_ROUND) ? md5_pkg::msg_idx(round_nx) : '0;

	md5_ram #(
		.WIDTH(md5_pkg::WORD_W),
		.DEPTH(md5_pkg::BUF_WORDS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		unique case (round_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			2'd3: f_val = c_q ^ (b_q | ~d_q);
			default: f_val = '0;
		endcase
		t_val = a_q + f_val + md5_pkg::k_const(round_q) + ram_rdata;
		rot_w = {t_val, t_val} << md5_pkg::rot_amt(round_q);
		b_new = b_q + rot_w[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ch_a_q    <= md5_pkg::INIT_A;
			ch_b_q    <= md5_pkg::INIT_B;
			ch_c_q    <= md5_pkg::INIT_C;
			ch_d_q    <= md5_pkg::INIT_D;
			cnt_q     <= '0;
			round_q   <= '0;
			bits_q    <= '0;
			pad_q     <= 1'b0;
			pad80_q   <= 1'b0;
			final_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !(st_q == ST_ADD && final_q)) begin
				out_valid <= 1'b0;
			end

			if (push_en) begin
				word_q[8*cnt_q[1:0] +: 8] <= push_val;
				cnt_q <= cnt_q + 6'd1;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						if (has_byte && cnt_q == 6'd63) begin
							pad_q <= last;
							st_q  <= ST_PRIME;
						end else if (last) begin
							pad_q <= 1'b1;
							st_q  <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!pad80_q) begin
						pad80_q <= 1'b1;
					end
					if (pad80_q && cnt_q == md5_pkg::LEN_POS) begin
						st_q <= ST_LEN_LO;
					end else if (cnt_q == 6'd63) begin
						st_q <= ST_PRIME;
					end
				end
				ST_LEN_LO: begin
					st_q <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					final_q <= 1'b1;
					st_q    <= ST_PRIME;
				end
				ST_PRIME: begin
					a_q     <= ch_a_q;
					b_q     <= ch_b_q;
					c_q     <= ch_c_q;
					d_q     <= ch_d_q;
					round_q <= '0;
					st_q    <= ST_ROUND;
				end
				ST_ROUND: begin
					a_q     <= d_q;
					d_q     <= c_q;
					c_q     <= b_q;
					b_q     <= b_new;
					round_q <= round_nx;
					if (round_q == md5_pkg::LAST_RND) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (final_q) begin
						// hold here until the previous digest has been taken
						if (!out_valid || out_ready) begin
							digest_low  <= {ch_b_q + b_q, ch_a_q + a_q};
							digest_high <= {ch_d_q + d_q, ch_c_q + c_q};
							out_valid   <= 1'b1;
							ch_a_q      <= md5_pkg::INIT_A;
							ch_b_q      <= md5_pkg::INIT_B;
							ch_c_q      <= md5_pkg::INIT_C;
							ch_d_q      <= md5_pkg::INIT_D;
							bits_q      <= '0;
							cnt_q       <= '0;
							pad_q       <= 1'b0;
							pad80_q     <= 1'b0;
							final_q     <= 1'b0;
							st_q        <= ST_IDLE;
						end
					end else begin
						ch_a_q <= ch_a_q + a_q;
						ch_b_q <= ch_b_q + b_q;
						ch_c_q <= ch_c_q + c_q;
						ch_d_q <= ch_d_q + d_q;
						st_q   <= pad_q ? ST_PAD : ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// rounds read the buffer; nothing may write it meanwhile
	a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND || st_q == ST_PRIME) |-> !ram_we)
		else $error("block buffer written during compression");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && round_q == md5_pkg::LAST_RND) |=> (st_q == ST_ADD))
		else $error("compression did not end after the last round");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LEN_LO) |-> (cnt_q == md5_pkg::LEN_POS && pad80_q))
		else $error("length written at wrong buffer position");

	a_digest_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(st_q) == ST_ADD && $past(final_q)))
		else $error("digest issued outside a final chaining add");
`endif

endmodule
